[sv/swdm_pkg.sv]
// ----------------------------------------------------------------------------
// swdm_pkg
// Shared types, codes and helper functions for the serial wire debug master.
// ----------------------------------------------------------------------------
`default_nettype none

package swdm_pkg;

   // item kinds carried on the request tuser
   localparam logic [1:0] KIND_QUEUE = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_RUN   = 2'd2;

   // ack codes from the target
   localparam logic [2:0] ACK_OK    = 3'd1;
   localparam logic [2:0] ACK_WAIT  = 3'd2;
   localparam logic [2:0] ACK_FAULT = 3'd4;

   // sticky status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_PARITY  = 2'd1;
   localparam logic [1:0] STAT_FAULT   = 2'd2;
   localparam logic [1:0] STAT_INVALID = 2'd3;

   // bit counts of each phase
   localparam logic [7:0] HEAD_BITS     = 8'd8;
   localparam logic [7:0] RD_ACK_BITS   = 8'd4;
   localparam logic [7:0] WR_ACK_BITS   = 8'd5;
   localparam logic [7:0] RD_DATA_BITS  = 8'd34;
   localparam logic [7:0] WR_DATA_BITS  = 8'd33;
   localparam logic [7:0] RUN_IDLE_BITS = 8'd8;

   // reset value of the ap idle register
   localparam logic [7:0] AP_IDLE_RESET = 8'd8;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HEAD   = 3'd1,
      PH_ACK    = 3'd2,
      PH_DATA   = 3'd3,
      PH_APIDLE = 3'd4,
      PH_RUN    = 3'd5
   } swdm_phase_type;

   // one input item as held in the input register
   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  request;
      logic [31:0] write_data;
      logic        swdio_in;
   } swdm_item_type;

   // one result item
   typedef struct packed {
      logic        swdio_out;
      logic        swdio_oe;
      logic        txn_done;
      logic        run_done;
      logic [31:0] read_data;
      logic [2:0]  ack;
      logic [1:0]  status;
   } swdm_result_type;

   // header bit at a position: start, apndp, rnw, a2, a3, parity, stop, park
   function automatic logic header_bit(input logic [3:0] req, input logic [2:0] idx);
      logic b;
      case (idx)
         3'd0:    b = 1'b1;
         3'd1:    b = req[0];
         3'd2:    b = req[1];
         3'd3:    b = req[2];
         3'd4:    b = req[3];
         3'd5:    b = ^req;
         3'd6:    b = 1'b0;
         default: b = 1'b1;
      endcase
      return b;
   endfunction

   // status after a transaction closes, from its ack
   function automatic logic [1:0] end_status(input logic [2:0] ack, input logic [1:0] cur);
      logic [1:0] s;
      if (ack == ACK_FAULT) begin
         s = STAT_FAULT;
      end else if (ack != ACK_OK && ack != ACK_WAIT) begin
         s = STAT_INVALID;
      end else begin
         s = cur;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

[sv/swdm_engine.sv]
// ----------------------------------------------------------------------------
// swdm_engine
// Transaction state and per-item update: header, ack, data, idle and run.
// ----------------------------------------------------------------------------
`default_nettype none

module swdm_engine
   import swdm_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            item_fire,
   input  wire swdm_item_type   item,
   input  wire logic [7:0]      ap_idle_cycles,
   output swdm_result_type      result
);

   swdm_phase_type phase_ff, phase_in;
   logic [7:0]     bit_count_ff, bit_count_in;
   logic [33:0]    shift_word_ff, shift_word_in;
   logic [3:0]     held_request_ff, held_request_in;
   logic [2:0]     ack_bits_ff, ack_bits_in;
   logic [31:0]    captured_data_ff, captured_data_in;
   logic [1:0]     sticky_status_ff, sticky_status_in;

   logic is_read;
   logic head_last;
   logic ack_last;
   logic data_last;
   logic run_last;
   logic ap_wait;
   logic dout;
   logic oe;
   logic tdone;
   logic rdone;

   // phase end flags
   assign is_read   = held_request_ff[1];
   assign head_last = bit_count_ff >= (HEAD_BITS - 8'd1);
   assign ack_last  = bit_count_ff >= ((is_read ? RD_ACK_BITS : WR_ACK_BITS) - 8'd1);
   assign data_last = bit_count_ff >= ((is_read ? RD_DATA_BITS : WR_DATA_BITS) - 8'd1);
   assign run_last  = bit_count_ff >= (RUN_IDLE_BITS - 8'd1);
   assign ap_wait   = held_request_ff[0] && (ap_idle_cycles != 8'd0);

   // next state
   always_comb begin
      phase_in         = phase_ff;
      bit_count_in     = bit_count_ff;
      shift_word_in    = shift_word_ff;
      held_request_in  = held_request_ff;
      ack_bits_in      = ack_bits_ff;
      captured_data_in = captured_data_ff;
      sticky_status_in = sticky_status_ff;
      if (item_fire) begin
         unique case (item.kind)
            KIND_QUEUE: begin
               if (phase_ff == PH_IDLE && sticky_status_ff == STAT_OK) begin
                  held_request_in = item.request;
                  shift_word_in   = {2'b00, item.write_data};
                  ack_bits_in     = 3'd0;
                  bit_count_in    = 8'd0;
                  phase_in        = PH_HEAD;
               end
            end
            KIND_RUN: begin
               if (phase_ff == PH_IDLE) begin
                  phase_in     = PH_RUN;
                  bit_count_in = 8'd0;
               end
            end
            KIND_TICK: begin
               unique case (phase_ff)
                  PH_IDLE: begin
                     phase_in = PH_IDLE;
                  end
                  PH_HEAD: begin
                     bit_count_in = bit_count_ff + 8'd1;
                     if (head_last) begin
                        phase_in     = PH_ACK;
                        bit_count_in = 8'd0;
                     end
                  end
                  PH_ACK: begin
                     // ack bits follow the first turnaround
                     if (bit_count_ff >= 8'd1 && bit_count_ff <= 8'd3) begin
                        ack_bits_in = ack_bits_ff |
                           (3'({2'b00, item.swdio_in}) << (bit_count_ff[1:0] - 2'd1));
                     end
                     bit_count_in = bit_count_ff + 8'd1;
                     if (ack_last) begin
                        phase_in     = PH_DATA;
                        bit_count_in = 8'd0;
                     end
                  end
                  PH_DATA: begin
                     if (is_read && bit_count_ff < RD_DATA_BITS) begin
                        shift_word_in[bit_count_ff[5:0]] = item.swdio_in;
                     end
                     bit_count_in = bit_count_ff + 8'd1;
                     if (data_last) begin
                        if (is_read) begin
                           captured_data_in = shift_word_ff[31:0];
                           if (shift_word_ff[32] != ^shift_word_ff[31:0]) begin
                              sticky_status_in = STAT_PARITY;
                           end
                        end
                        if (ap_wait) begin
                           phase_in     = PH_APIDLE;
                           bit_count_in = ap_idle_cycles;
                        end else begin
                           sticky_status_in = end_status(ack_bits_ff, sticky_status_in);
                           phase_in         = PH_IDLE;
                           bit_count_in     = 8'd0;
                        end
                     end
                  end
                  PH_APIDLE: begin
                     if (bit_count_ff > 8'd0) begin
                        bit_count_in = bit_count_ff - 8'd1;
                     end
                     if (bit_count_ff <= 8'd1) begin
                        sticky_status_in = end_status(ack_bits_ff, sticky_status_ff);
                        phase_in         = PH_IDLE;
                        bit_count_in     = 8'd0;
                     end
                  end
                  PH_RUN: begin
                     bit_count_in = bit_count_ff + 8'd1;
                     if (run_last) begin
                        sticky_status_in = STAT_OK;
                        phase_in         = PH_IDLE;
                        bit_count_in     = 8'd0;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // line drive and done flags for a tick
   always_comb begin
      dout  = 1'b0;
      oe    = 1'b1;
      tdone = 1'b0;
      rdone = 1'b0;
      unique case (phase_ff)
         PH_HEAD: begin
            dout = header_bit(held_request_ff, bit_count_ff[2:0]);
         end
         PH_ACK: begin
            oe = 1'b0;
         end
         PH_DATA: begin
            if (is_read) begin
               oe = 1'b0;
            end else if (bit_count_ff < 8'd32) begin
               dout = shift_word_ff[bit_count_ff[5:0]];
            end else begin
               dout = ^shift_word_ff[31:0];
            end
            tdone = data_last && !ap_wait;
         end
         PH_APIDLE: begin
            tdone = bit_count_ff <= 8'd1;
         end
         PH_RUN: begin
            rdone = run_last;
         end
         default: begin
            dout = 1'b0;
         end
      endcase
   end

   // result item
   always_comb begin
      result.swdio_out = dout & oe;
      result.swdio_oe  = oe;
      result.txn_done  = tdone;
      result.run_done  = rdone;
      result.read_data = captured_data_in;
      result.ack       = ack_bits_in;
      result.status    = (phase_ff == PH_RUN) ? sticky_status_ff : sticky_status_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         bit_count_ff     <= 8'd0;
         shift_word_ff    <= 34'd0;
         held_request_ff  <= 4'd0;
         ack_bits_ff      <= 3'd0;
         captured_data_ff <= 32'd0;
         sticky_status_ff <= STAT_OK;
      end else begin
         phase_ff         <= phase_in;
         bit_count_ff     <= bit_count_in;
         shift_word_ff    <= shift_word_in;
         held_request_ff  <= held_request_in;
         ack_bits_ff      <= ack_bits_in;
         captured_data_ff <= captured_data_in;
         sticky_status_ff <= sticky_status_in;
      end
   end

endmodule

`default_nettype wire

[sv/swd_master_transaction_top.sv]
// ----------------------------------------------------------------------------
// swd_master_transaction_top
// Serial wire debug master: queues one access, then drives or samples one
// line bit per tick item, with sticky error status and run flush.
// ----------------------------------------------------------------------------
//
//   channel   direction  ports                  contents
//   req       in         req_tvalid/tready      tuser kind, tdata request item
//   rsp       out        rsp_tvalid/tready      tdata line bit and status, tlast
//   csr       in         csr_valid/ready        ap idle cycle count
//
// One item per cycle unless a tick item waits on a stalled result: an item is
// held in the input register, the engine updates its state from it and a
// tick result lands in the output register. Queue and run items give no result.
// Reset clears the valid flags and the engine state; the ap idle count returns to 8.
// A stalled result holds the input register only once the item there
// would produce another result.
`default_nettype none

module swd_master_transaction_top
   import swdm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // request[3:0], write_data[35:4], swdio_in[36], zero
   input  wire logic [1:0]  req_tuser,   // kind[1:0]
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // swdio_out[0], swdio_oe[1], run_done[2],
                                         // read_data[34:3], ack[37:35], status[39:38]
   output logic             rsp_tlast,   // txn_done
   // configuration write
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_data     // ap_idle_cycles
);

   logic            in_valid_ff, in_valid_in;
   swdm_item_type   in_item_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   swdm_result_type rsp_ff;
   logic [7:0]      ap_idle_ff;
   logic            out_free;
   logic            has_result;
   logic            advance;
   swdm_result_type result;

   // config register, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ap_idle_ff <= AP_IDLE_RESET;
      end else if (csr_valid) begin
         ap_idle_ff <= csr_data;
      end
   end

   // handshake between the stages
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign has_result = in_item_ff.kind == KIND_TICK;
   assign advance    = in_valid_ff && (!has_result || out_free);
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = (advance && has_result) ? 1'b1 :
                         (rsp_tready ? 1'b0 : rsp_valid_ff);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.kind       <= req_tuser;
         in_item_ff.request    <= req_tdata[3:0];
         in_item_ff.write_data <= req_tdata[35:4];
         in_item_ff.swdio_in   <= req_tdata[36];
      end
   end

   swdm_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .item_fire      (advance),
      .item           (in_item_ff),
      .ap_idle_cycles (ap_idle_ff),
      .result         (result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_ff.txn_done;
   assign rsp_tdata  = {rsp_ff.status, rsp_ff.ack, rsp_ff.read_data,
                        rsp_ff.run_done, rsp_ff.swdio_oe, rsp_ff.swdio_out};

   // a transaction end and a run end never share a tick
   a_done_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tlast && rsp_tdata[2]))
      else $error("txn_done and run_done together");

   // the line is only driven high while output enable is set
   a_drive_needs_oe: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("swdio_out high without swdio_oe");

   // a held item blocked by a full output stays in the input register
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("blocked input item lost");

endmodule

`default_nettype wire
